// ----- design/tsct_pkg.sv -----
// Shared constants, types and arithmetic helpers for the Taylor sine/cosine/tangent block.
package tsct_pkg;

  // Number formats
  localparam int SERIES_TERMS     = 22;
  localparam int ANGLE_FRAC_BITS  = 24;
  localparam int RESULT_FRAC_BITS = 32;
  localparam int WORK_FRAC        = 52;
  localparam int TWO_PI_FRAC      = 60;
  localparam int ANGLE_W          = 56;
  localparam int VALUE_W          = 48;
  localparam int CMD_W            = 2;
  localparam int WORD_W           = 64;

  // Two pi in Q60, truncated
  localparam logic [62:0] TWO_PI_Q60 = 63'h6487ED5110B4611A;

  // Angle reduction: one restoring step per angle bit plus the extra fraction bits
  localparam int RED_STEPS = ANGLE_W + TWO_PI_FRAC - ANGLE_FRAC_BITS;
  localparam int RED_SHIFT = TWO_PI_FRAC - WORK_FRAC;

  // Result rounding and tangent divider sizes
  localparam int RES_SHIFT = WORK_FRAC - RESULT_FRAC_BITS;
  localparam int DIVD_W    = WORD_W + RESULT_FRAC_BITS;
  localparam int QUOT_W    = VALUE_W + 1;
  localparam logic [QUOT_W:0] QUOT_CAP = (QUOT_W + 1)'(1) << VALUE_W;

  // Factorial pair divisor width, sized for the bound 2N * (2N + 1)
  localparam int FACT_W = $clog2(2 * SERIES_TERMS * (2 * SERIES_TERMS + 1) + 1);

  localparam logic [WORD_W-1:0] VALUE_MAXPOS = (WORD_W'(1) << (VALUE_W - 1)) - WORD_W'(1);
  localparam logic [WORD_W-1:0] VALUE_NEGMAG = WORD_W'(1) << (VALUE_W - 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_SIN  = 2'd0,
    CMD_COS  = 2'd1,
    CMD_TAN  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  // Four 32x32 partial products of a 64x64 multiply
  typedef logic [3:0][63:0] pp_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               ovf;
  } sat_t;

  // Sideband that rides along the tangent divider
  typedef struct packed {
    cmd_t               cmd;
    logic               use_div;
    logic               neg;
    logic [VALUE_W-1:0] value;
    logic               ovf;
  } div_tag_t;

  function automatic pp_t pp4(input logic [63:0] a, input logic [63:0] b);
    logic [31:0] a0;
    logic [31:0] a1;
    logic [31:0] b0;
    logic [31:0] b1;
    pp_t         p;
    a0 = a[31:0];
    a1 = a[63:32];
    b0 = b[31:0];
    b1 = b[63:32];
    p[0] = 64'(a0) * 64'(b0);
    p[1] = 64'(a0) * 64'(b1);
    p[2] = 64'(a1) * 64'(b0);
    p[3] = 64'(a1) * 64'(b1);
    return p;
  endfunction

  function automatic logic [127:0] pp_sum(input pp_t p);
    return 128'(p[0]) + (128'(p[1]) << 32) + (128'(p[2]) << 32) + (128'(p[3]) << 64);
  endfunction

  // Product in Q104 back to Q52, half away from zero on the magnitude
  function automatic logic [63:0] q52_round(input logic [127:0] p);
    logic [127:0] s;
    s = p + (128'(1) << (WORK_FRAC - 1));
    return s[WORK_FRAC+63:WORK_FRAC];
  endfunction

  // Q52 magnitude to the result format, half away from zero
  function automatic logic [63:0] res_round(input logic [63:0] m);
    logic [63:0] s;
    s = m + (64'(1) << (RES_SHIFT - 1));
    return s >> RES_SHIFT;
  endfunction

  function automatic sat_t saturate(input logic neg, input logic [63:0] mag);
    logic [63:0] m;
    sat_t        r;
    m     = mag;
    r.ovf = 1'b0;
    if (neg) begin
      if (m > VALUE_NEGMAG) begin
        m     = VALUE_NEGMAG;
        r.ovf = 1'b1;
      end
      m = -m;
    end else begin
      if (m > VALUE_MAXPOS) begin
        m     = VALUE_MAXPOS;
        r.ovf = 1'b1;
      end
    end
    r.value = m[VALUE_W-1:0];
    return r;
  endfunction

endpackage

// ----- design/taylor_sin_cos_tan.sv -----
// Top level of the fixed-point sine, cosine and tangent pipeline.
// Takes one beat per clock and returns one result beat per input beat, in order, through
// 1 input register, 92 angle reduction stages (one restoring step against two pi per
// stage), 3 stages that form x and x squared, 127 series stages (six per Taylor term for
// the multiply by x squared and the reciprocal divide by the factor pair, one for the last
// term), 1 result stage, 96 tangent divider stages (one quotient bit each), 1 rounding
// stage and the output register. Every operation takes the same path, so sine, cosine and
// tangent beats mix freely. When the output beat is not taken the whole pipeline holds
// and s_tready drops. Reset only clears valid bits.
module taylor_sin_cos_tan (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // angle
  input  logic [1:0]  s_tuser,   // cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // value
  output logic [0:0]  m_tuser    // overflow
);

  localparam int RS = tsct_pkg::RED_STEPS;
  localparam int AW = tsct_pkg::ANGLE_W;

  logic en;

  // Whole pipeline advances unless a result beat is stuck at the output
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Input register: magnitude and sign of the angle
  logic           in_v;
  tsct_pkg::cmd_t in_cmd;
  logic           in_neg;
  logic [AW-1:0]  in_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (en) begin
      in_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_cmd <= tsct_pkg::cmd_t'(s_tuser);
      in_neg <= s_tdata[AW-1];
      in_mag <= s_tdata[AW-1] ? -s_tdata : s_tdata;
    end
  end

  // Angle reduction, one restoring step per stage
  logic           rv [RS+1];
  tsct_pkg::cmd_t rc [RS+1];
  logic           rn [RS+1];
  logic [AW-1:0]  rm [RS+1];
  logic [62:0]    rr [RS+1];

  assign rv[0] = in_v;
  assign rc[0] = in_cmd;
  assign rn[0] = in_neg;
  assign rm[0] = in_mag;
  assign rr[0] = '0;

  for (genvar k = 0; k < RS; k++) begin : g_red
    logic           v_r;
    tsct_pkg::cmd_t c_r;
    logic           n_r;
    logic [AW-1:0]  m_r;
    logic [62:0]    r_r;
    logic [63:0]    r_sh;
    logic [63:0]    r_sub;

    always_comb begin
      r_sh  = {rr[k], rm[k][AW-1]};
      r_sub = r_sh - 64'(tsct_pkg::TWO_PI_Q60);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= rv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        c_r <= rc[k];
        n_r <= rn[k];
        m_r <= rm[k] << 1;
        r_r <= (r_sh >= 64'(tsct_pkg::TWO_PI_Q60)) ? r_sub[62:0] : r_sh[62:0];
      end
    end

    assign rv[k+1] = v_r;
    assign rc[k+1] = c_r;
    assign rn[k+1] = n_r;
    assign rm[k+1] = m_r;
    assign rr[k+1] = r_r;
  end

  // Round the remainder to Q52, then form signed x and x squared
  logic           x1_v, x2_v, x3_v;
  tsct_pkg::cmd_t x1_c, x2_c, x3_c;
  logic           x1_n;
  logic [AW-1:0]  x1_m;
  logic [63:0]    x1_m64;
  logic [63:0]    red_round;
  logic signed [63:0] x2_x, x3_x;
  tsct_pkg::pp_t  x2_pp;
  logic [63:0]    x3_sq;

  always_comb begin
    red_round = (64'(rr[RS]) + (64'(1) << (tsct_pkg::RED_SHIFT - 1))) >> tsct_pkg::RED_SHIFT;
    x1_m64    = 64'(x1_m);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x1_v <= 1'b0;
      x2_v <= 1'b0;
      x3_v <= 1'b0;
    end else if (en) begin
      x1_v <= rv[RS];
      x2_v <= x1_v;
      x3_v <= x2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_c  <= rc[RS];
      x1_n  <= rn[RS];
      x1_m  <= red_round[AW-1:0];

      x2_c  <= x1_c;
      x2_x  <= x1_n ? -$signed(x1_m64) : $signed(x1_m64);
      x2_pp <= tsct_pkg::pp4(x1_m64, x1_m64);

      x3_c  <= x2_c;
      x3_x  <= x2_x;
      x3_sq <= tsct_pkg::q52_round(tsct_pkg::pp_sum(x2_pp));
    end
  end

  // Series for sine and cosine
  logic               se_v;
  tsct_pkg::cmd_t     se_c;
  logic signed [63:0] se_sin;
  logic signed [63:0] se_cos;

  tsct_series u_series (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (x3_v),
    .in_cmd    (x3_c),
    .in_x      (x3_x),
    .in_x2     (x3_sq),
    .out_valid (se_v),
    .out_cmd   (se_c),
    .out_sin   (se_sin),
    .out_cos   (se_cos)
  );

  // Result stage: sine and cosine results, tangent divider operands
  logic [63:0]        s_mag, c_mag;
  tsct_pkg::sat_t     sin_sat, cos_sat;
  tsct_pkg::div_tag_t r1_tag_next;
  logic               r1_v;
  tsct_pkg::div_tag_t r1_tag;
  logic [tsct_pkg::DIVD_W-1:0] r1_num;
  logic [63:0]        r1_den;

  always_comb begin
    s_mag   = se_sin[63] ? 64'(-se_sin) : 64'(se_sin);
    c_mag   = se_cos[63] ? 64'(-se_cos) : 64'(se_cos);
    sin_sat = tsct_pkg::saturate(se_sin[63], tsct_pkg::res_round(s_mag));
    cos_sat = tsct_pkg::saturate(se_cos[63], tsct_pkg::res_round(c_mag));
    r1_tag_next.cmd     = se_c;
    r1_tag_next.use_div = 1'b0;
    r1_tag_next.neg     = se_sin[63] ^ se_cos[63];
    r1_tag_next.value   = '0;
    r1_tag_next.ovf     = 1'b0;
    case (se_c)
      tsct_pkg::CMD_SIN: begin
        r1_tag_next.value = sin_sat.value;
        r1_tag_next.ovf   = sin_sat.ovf;
      end
      tsct_pkg::CMD_COS: begin
        r1_tag_next.value = cos_sat.value;
        r1_tag_next.ovf   = cos_sat.ovf;
      end
      tsct_pkg::CMD_TAN: begin
        if (c_mag == '0) begin
          // zero cosine saturates toward the sign of sine
          r1_tag_next.ovf   = 1'b1;
          r1_tag_next.value = se_sin[63] ? tsct_pkg::VALUE_NEGMAG[tsct_pkg::VALUE_W-1:0]
                                         : tsct_pkg::VALUE_MAXPOS[tsct_pkg::VALUE_W-1:0];
        end else begin
          r1_tag_next.use_div = 1'b1;
        end
      end
      default: begin
        r1_tag_next.value = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_v <= 1'b0;
    end else if (en) begin
      r1_v <= se_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_tag <= r1_tag_next;
      r1_num <= {s_mag, {tsct_pkg::RESULT_FRAC_BITS{1'b0}}};
      r1_den <= c_mag;
    end
  end

  // Tangent quotient
  logic                          dv_v;
  tsct_pkg::div_tag_t            dv_tag;
  logic [tsct_pkg::QUOT_W-1:0]   dv_q;
  logic [63:0]                   dv_rem;
  logic [63:0]                   dv_den;

  tsct_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (r1_v),
    .in_tag    (r1_tag),
    .in_num    (r1_num),
    .in_den    (r1_den),
    .out_valid (dv_v),
    .out_tag   (dv_tag),
    .out_quot  (dv_q),
    .out_rem   (dv_rem),
    .out_den   (dv_den)
  );

  // Round the quotient to nearest, halves up, unless capped
  logic                          f1_v;
  tsct_pkg::div_tag_t            f1_tag;
  logic [tsct_pkg::QUOT_W-1:0]   f1_q;
  logic                          rnd_up;

  always_comb begin
    rnd_up = ({1'b0, dv_q} < tsct_pkg::QUOT_CAP) && ({dv_rem, 1'b0} >= {1'b0, dv_den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
    end else if (en) begin
      f1_v <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_tag <= dv_tag;
      f1_q   <= dv_q + tsct_pkg::QUOT_W'(rnd_up);
    end
  end

  // Output register
  tsct_pkg::sat_t tan_sat;

  always_comb begin
    tan_sat = tsct_pkg::saturate(f1_tag.neg, 64'(f1_q));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= f1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (f1_tag.use_div) begin
        m_tdata    <= tan_sat.value;
        m_tuser[0] <= tan_sat.ovf;
      end else begin
        m_tdata    <= f1_tag.value;
        m_tuser[0] <= f1_tag.ovf;
      end
    end
  end

endmodule

// ----- design/tsct_series.sv -----
// Pipelined sine and cosine Taylor series, one term per six stages.
module tsct_series (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  tsct_pkg::cmd_t      in_cmd,
  input  logic signed [63:0]  in_x,
  input  logic [63:0]         in_x2,
  output logic                out_valid,
  output tsct_pkg::cmd_t      out_cmd,
  output logic signed [63:0]  out_sin,
  output logic signed [63:0]  out_cos
);

  localparam int N = tsct_pkg::SERIES_TERMS;

  // Values entering each term; lane 0 is sine, lane 1 cosine
  logic               bv  [N];
  tsct_pkg::cmd_t     bc  [N];
  logic [63:0]        bx2 [N-1];
  logic signed [63:0] bt  [N][2];
  logic signed [63:0] bs  [N][2];

  assign bv[0]     = in_valid;
  assign bc[0]     = in_cmd;
  assign bx2[0]    = in_x2;
  assign bt[0][0]  = in_x;
  assign bt[0][1]  = 64'(1) << tsct_pkg::WORK_FRAC;
  assign bs[0][0]  = '0;
  assign bs[0][1]  = '0;

  for (genvar i = 0; i < N; i++) begin : g_term
    if (i < N - 1) begin : g_step
      logic           v_a, v_b, v_c, v_d, v_e, v_f;
      tsct_pkg::cmd_t c_a, c_b, c_c, c_d, c_e, c_f;

      // Valid shift line
      always_ff @(posedge clk) begin
        if (rst) begin
          v_a <= 1'b0;
          v_b <= 1'b0;
          v_c <= 1'b0;
          v_d <= 1'b0;
          v_e <= 1'b0;
          v_f <= 1'b0;
        end else if (en) begin
          v_a <= bv[i];
          v_b <= v_a;
          v_c <= v_b;
          v_d <= v_c;
          v_e <= v_d;
          v_f <= v_e;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          c_a <= bc[i];
          c_b <= c_a;
          c_c <= c_b;
          c_d <= c_c;
          c_e <= c_d;
          c_f <= c_e;
        end
      end

      assign bv[i+1] = v_f;
      assign bc[i+1] = c_f;

      // x squared travels on to the next term
      if (i < N - 2) begin : g_fwd
        logic [63:0] x_a, x_b, x_c, x_d, x_e, x_f;
        always_ff @(posedge clk) begin
          if (en) begin
            x_a <= bx2[i];
            x_b <= x_a;
            x_c <= x_b;
            x_d <= x_c;
            x_e <= x_d;
            x_f <= x_e;
          end
        end
        assign bx2[i+1] = x_f;
      end

      for (genvar j = 0; j < 2; j++) begin : g_lane
        localparam int P = 2 * i + ((j == 0) ? 1 : 0);
        localparam int D = (P + 1) * (P + 2);
        localparam logic [64:0] RECIP_FULL = (65'd1 << 64) / 65'(D);
        localparam logic [63:0] RECIP = RECIP_FULL[63:0];
        localparam logic [tsct_pkg::FACT_W-1:0] DIV = tsct_pkg::FACT_W'(D);

        logic signed [63:0] sum_a, sum_b, sum_c, sum_d, sum_e, sum_f;
        logic               neg_a, neg_b, neg_c, neg_d, neg_e;
        tsct_pkg::pp_t      pr_a, pr_c;
        logic [63:0]        prod_b, prod_c, prod_d;
        logic [63:0]        q0_d, q0_e, rem_e;
        logic signed [63:0] t_f;
        logic [63:0]        mag_t;
        logic [127:0]       recip_prod;
        logic [63:0]        quot;

        always_comb begin
          mag_t      = bt[i][j][63] ? 64'(-bt[i][j]) : 64'(bt[i][j]);
          recip_prod = tsct_pkg::pp_sum(pr_c);
          quot       = q0_e + 64'(rem_e >= 64'(DIV));
        end

        // term * x^2, then divide by the factor pair through a reciprocal
        always_ff @(posedge clk) begin
          if (en) begin
            sum_a  <= bs[i][j] + bt[i][j];
            neg_a  <= bt[i][j][63];
            pr_a   <= tsct_pkg::pp4(mag_t, bx2[i]);

            sum_b  <= sum_a;
            neg_b  <= neg_a;
            prod_b <= tsct_pkg::q52_round(tsct_pkg::pp_sum(pr_a));

            sum_c  <= sum_b;
            neg_c  <= neg_b;
            prod_c <= prod_b;
            pr_c   <= tsct_pkg::pp4(prod_b, RECIP);

            sum_d  <= sum_c;
            neg_d  <= neg_c;
            prod_d <= prod_c;
            q0_d   <= recip_prod[127:64];

            sum_e  <= sum_d;
            neg_e  <= neg_d;
            q0_e   <= q0_d;
            rem_e  <= prod_d - q0_d * 64'(DIV);

            sum_f  <= sum_e;
            t_f    <= neg_e ? $signed(quot) : -$signed(quot);
          end
        end

        assign bt[i+1][j] = t_f;
        assign bs[i+1][j] = sum_f;
      end
    end else begin : g_last
      logic               v_z;
      tsct_pkg::cmd_t     c_z;
      logic signed [63:0] s_z;
      logic signed [63:0] k_z;

      always_ff @(posedge clk) begin
        if (rst) begin
          v_z <= 1'b0;
        end else if (en) begin
          v_z <= bv[i];
        end
      end

      // Last term only adds
      always_ff @(posedge clk) begin
        if (en) begin
          c_z <= bc[i];
          s_z <= bs[i][0] + bt[i][0];
          k_z <= bs[i][1] + bt[i][1];
        end
      end

      assign out_valid = v_z;
      assign out_cmd   = c_z;
      assign out_sin   = s_z;
      assign out_cos   = k_z;
    end
  end

endmodule

// ----- design/tsct_div.sv -----
// Pipelined restoring divider for the tangent quotient, one bit per stage, capped.
module tsct_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  tsct_pkg::div_tag_t            in_tag,
  input  logic [tsct_pkg::DIVD_W-1:0]   in_num,
  input  logic [63:0]                   in_den,
  output logic                          out_valid,
  output tsct_pkg::div_tag_t            out_tag,
  output logic [tsct_pkg::QUOT_W-1:0]   out_quot,
  output logic [63:0]                   out_rem,
  output logic [63:0]                   out_den
);

  localparam int S  = tsct_pkg::DIVD_W;
  localparam int QW = tsct_pkg::QUOT_W;

  logic                 sv [S+1];
  tsct_pkg::div_tag_t   st [S+1];
  logic [S-1:0]         sn [S+1];
  logic [63:0]          sd [S+1];
  logic [63:0]          sr [S+1];
  logic [QW-1:0]        sq [S+1];

  assign sv[0] = in_valid;
  assign st[0] = in_tag;
  assign sn[0] = in_num;
  assign sd[0] = in_den;
  assign sr[0] = '0;
  assign sq[0] = '0;

  for (genvar k = 0; k < S; k++) begin : g_bit
    logic                 v_r;
    tsct_pkg::div_tag_t   t_r;
    logic [S-1:0]         n_r;
    logic [63:0]          d_r;
    logic [63:0]          r_r;
    logic [QW-1:0]        q_r;
    logic [64:0]          rem_sh;
    logic                 take;
    logic [64:0]          rem_sub;
    logic [QW:0]          q_sh;

    // Shift in the next dividend bit, compare and subtract, cap the quotient
    always_comb begin
      rem_sh  = {sr[k], sn[k][S-1]};
      take    = rem_sh >= {1'b0, sd[k]};
      rem_sub = rem_sh - {1'b0, sd[k]};
      q_sh    = {sq[k], take};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= sv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        t_r <= st[k];
        n_r <= sn[k] << 1;
        d_r <= sd[k];
        r_r <= take ? rem_sub[63:0] : rem_sh[63:0];
        q_r <= (q_sh > tsct_pkg::QUOT_CAP) ? tsct_pkg::QUOT_CAP[QW-1:0] : q_sh[QW-1:0];
      end
    end

    assign sv[k+1] = v_r;
    assign st[k+1] = t_r;
    assign sn[k+1] = n_r;
    assign sd[k+1] = d_r;
    assign sr[k+1] = r_r;
    assign sq[k+1] = q_r;
  end

  assign out_valid = sv[S];
  assign out_tag   = st[S];
  assign out_quot  = sq[S];
  assign out_rem   = sr[S];
  assign out_den   = sd[S];

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the Taylor sine, cosine and tangent pipeline.
`timescale 1ns / 100ps

module tb;

  localparam int PIPE_LAT   = 322;
  localparam int CYCLE_CAP  = 400000;
  localparam int STALL_LEN  = 700;
  localparam longint HALF_PI_A = 64'd26353589;   // pi/2 in the angle format
  localparam longint PI_A      = 64'd52707179;
  localparam longint TWO_PI_A  = 64'd105414357;

  typedef struct packed {
    logic [tsct_pkg::VALUE_W-1:0] value;
    logic                         ovf;
  } trig_res_t;

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [55:0]        s_tdata;   // angle
  logic [1:0]         s_tuser;   // cmd
  logic               m_tvalid;
  logic               m_tready;
  logic [47:0]        m_tdata;   // value
  logic [0:0]         m_tuser;   // overflow

  trig_res_t pending_res[$];
  int        send_idle_pct;
  int        recv_idle_pct;
  int        mismatches;
  int        results_seen;
  int        ovf_seen;
  int        cmd_count[4];
  int        cycles;
  bit        stall_go;
  bit        stall_on;

  taylor_sin_cos_tan dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------- predictor
  // Q52 product rounded half up on magnitudes
  function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    prod = prod + (128'd1 << 51);
    return prod[115:52];
  endfunction

  function automatic logic [63:0] abs64(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint taylor_sum(input longint first, input logic [63:0] x2,
                                        input int odd);
    longint      sum;
    longint      t;
    logic [63:0] q;
    logic [63:0] p;
    sum = 0;
    t   = first;
    for (int i = 0; i < tsct_pkg::SERIES_TERMS; i++) begin
      p   = 64'(2 * i + odd);
      sum = sum + t;
      q   = fx_mul(abs64(t), x2) / ((p + 1) * (p + 2));
      t   = (t < 0) ? longint'(q) : -longint'(q);
    end
    return sum;
  endfunction

  function automatic trig_res_t clamp48(input logic neg, input logic [63:0] mag);
    trig_res_t   r;
    logic [63:0] m;
    m     = mag;
    r.ovf = 1'b0;
    if (neg) begin
      if (m > tsct_pkg::VALUE_NEGMAG) begin
        m     = tsct_pkg::VALUE_NEGMAG;
        r.ovf = 1'b1;
      end
      m = -m;
    end else if (m > tsct_pkg::VALUE_MAXPOS) begin
      m     = tsct_pkg::VALUE_MAXPOS;
      r.ovf = 1'b1;
    end
    r.value = m[tsct_pkg::VALUE_W-1:0];
    return r;
  endfunction

  function automatic trig_res_t series_out(input longint v);
    logic [63:0] m;
    m = (abs64(v) + (64'd1 << 19)) >> 20;
    return clamp48(v < 0, m);
  endfunction

  // |s| * 2^32 / |c|, quotient capped at 2^48, rounded to nearest
  function automatic logic [63:0] tan_quot(input logic [63:0] sm, input logic [63:0] d);
    logic [127:0] num;
    logic [63:0]  rem;
    logic [63:0]  q;
    logic         qb;
    num = {64'd0, sm} << 32;
    rem = 0;
    q   = 0;
    for (int i = 127; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      qb  = 1'b0;
      if (rem >= d) begin
        rem = rem - d;
        qb  = 1'b1;
      end
      q = {q[62:0], qb};
      if (q > (64'd1 << 48)) q = 64'd1 << 48;
    end
    if (q < (64'd1 << 48) && rem * 2 >= d) q = q + 1;
    return q;
  endfunction

  function automatic trig_res_t trig_predict(input tsct_pkg::cmd_t op, input logic [55:0] a);
    trig_res_t   r;
    logic        neg;
    logic [55:0] m;
    logic [63:0] rr;
    logic [63:0] xm;
    logic [63:0] x2;
    longint      x;
    longint      s;
    longint      c;
    neg = a[55];
    m   = neg ? (~a + 56'd1) : a;
    rr  = 0;
    for (int i = 55; i >= 0; i--) begin
      rr = {rr[62:0], m[i]};
      if (rr >= 64'(tsct_pkg::TWO_PI_Q60)) rr = rr - 64'(tsct_pkg::TWO_PI_Q60);
    end
    for (int i = 0; i < tsct_pkg::TWO_PI_FRAC - tsct_pkg::ANGLE_FRAC_BITS; i++) begin
      rr = rr << 1;
      if (rr >= 64'(tsct_pkg::TWO_PI_Q60)) rr = rr - 64'(tsct_pkg::TWO_PI_Q60);
    end
    xm = (rr + 64'd128) >> 8;
    x  = neg ? -longint'(xm) : longint'(xm);
    x2 = fx_mul(xm, xm);
    r  = '0;
    case (op)
      tsct_pkg::CMD_SIN: r = series_out(taylor_sum(x, x2, 1));
      tsct_pkg::CMD_COS: r = series_out(taylor_sum(longint'(1) << tsct_pkg::WORK_FRAC, x2, 0));
      tsct_pkg::CMD_TAN: begin
        s = taylor_sum(x, x2, 1);
        c = taylor_sum(longint'(1) << tsct_pkg::WORK_FRAC, x2, 0);
        if (c == 0) begin
          r.ovf   = 1'b1;
          r.value = (s < 0) ? tsct_pkg::VALUE_NEGMAG[tsct_pkg::VALUE_W-1:0]
                            : tsct_pkg::VALUE_MAXPOS[tsct_pkg::VALUE_W-1:0];
        end else begin
          r = clamp48((s < 0) != (c < 0), tan_quot(abs64(s), abs64(c)));
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- driver
  task automatic send_angle(input tsct_pkg::cmd_t op, input logic [55:0] a);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= a;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_res.push_back(trig_predict(op, a));
    cmd_count[op]++;
  endtask

  function automatic logic [55:0] rand_angle();
    logic [55:0] a;
    case ($urandom_range(5))
      0, 1: a = 56'($signed($urandom_range(2 * TWO_PI_A)) - TWO_PI_A);
      2: a = 56'({$urandom(), $urandom()});
      3: a = 56'($signed({$urandom(), $urandom()}) >>> $urandom_range(40));
      4: a = 56'(HALF_PI_A + $signed($urandom_range(64)) - 32
                 + PI_A * $signed($urandom_range(20) - 10));
      default: a = 56'($signed($urandom_range(2000)) - 1000);
    endcase
    return a;
  endfunction

  function automatic tsct_pkg::cmd_t rand_cmd();
    return ($urandom_range(19) == 0) ? tsct_pkg::CMD_NONE
                                     : tsct_pkg::cmd_t'($urandom_range(2));
  endfunction

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (m_tuser[0]) ovf_seen++;
        if (pending_res.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("ERROR: result beat with nothing pending");
        end else begin
          trig_res_t want;
          want = pending_res.pop_front();
          if (m_tdata !== want.value || m_tuser[0] !== want.ovf) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: value %h ovf %b, expected value %h ovf %b",
                       m_tdata, m_tuser[0], want.value, want.ovf);
          end
        end
      end
    end
    m_tready <= !stall_on && ($urandom_range(99) >= recv_idle_pct);
  end

  // Long receiver hold-off
  always @(posedge clk) begin
    if (stall_go && !stall_on) begin
      stall_on <= 1'b1;
      repeat (STALL_LEN) @(posedge clk);
      stall_on <= 1'b0;
      stall_go <= 1'b0;
    end
  end

  // Run watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    logic [55:0] edges[$];
    edges = '{56'd0, 56'd1, -56'd1, 56'h7FFFFFFFFFFFFF, 56'h80000000000000,
              56'(HALF_PI_A), -56'(HALF_PI_A), 56'(PI_A), 56'(TWO_PI_A),
              -56'(TWO_PI_A), 56'(3 * HALF_PI_A)};
    foreach (edges[i]) begin
      send_angle(tsct_pkg::CMD_SIN, edges[i]);
      send_angle(tsct_pkg::CMD_COS, edges[i]);
    end
    foreach (edges[i]) send_angle(tsct_pkg::CMD_TAN, edges[i]);
    send_angle(tsct_pkg::CMD_NONE, 56'(HALF_PI_A));
  endtask

  task automatic test_random(input int n, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n; i++) send_angle(rand_cmd(), rand_angle());
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_go      = 1'b1;
    for (int i = 0; i < 400; i++) send_angle(rand_cmd(), rand_angle());
  endtask

  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = tsct_pkg::CMD_SIN;
    m_tready      = 1'b0;
    stall_go      = 1'b0;
    stall_on      = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    mismatches    = 0;
    results_seen  = 0;
    ovf_seen      = 0;
    cycles        = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(350, 24, 66);
    test_random(350, 66, 24);
    test_random(300, 0, 0);
    test_backpressure();

    s_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 20) @(posedge clk);

    $display("Covered %0d sine, %0d cosine, %0d tangent and %0d unused-code beats.",
             cmd_count[tsct_pkg::CMD_SIN], cmd_count[tsct_pkg::CMD_COS],
             cmd_count[tsct_pkg::CMD_TAN], cmd_count[tsct_pkg::CMD_NONE]);
    $display("Checked %0d results, %0d flagged overflow, %0d mismatches.",
             results_seen, ovf_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/tsct_pkg.sv
design/tsct_series.sv
design/tsct_div.sv
design/taylor_sin_cos_tan.sv
verif/tb.sv
